>>> hw/rtl/lkc_pkg.sv
`timescale 1ns / 1ps
package lkc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W  = 5;
    localparam int OCC_W  = 5;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(16);
    localparam logic             REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_EVICT  = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    // broadcast to every cell for the compare
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    count;
    } t_probe;

    // update command from the control logic
    typedef struct packed {
        logic             lookup_en;
        logic             insert_en;
        logic [CNT_W-1:0] insert_limit;
    } t_cell_cmd;

endpackage

>>> hw/rtl/lru_key_cache_core.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        sink       i_in_valid / o_in_stall    i_action, i_key
// out       source     o_out_valid / i_out_stall  o_hit, o_status, o_evicted_valid,
//                                                 o_evicted_key, o_occupancy
// cfg       apb slave  psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// one transaction per cycle while the input is not stalled: compare against every cell, the match
// chain along the cells and the shift decision all settle in the accept cycle
// the result is registered in the output register and appears in the cycle after accept
// reset clears occupancy and the output valid and sets capacity to 16
// input stalls only while a result is held and the output is stalled
module lru_key_cache_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_action,
    input  logic [lkc_pkg::KEY_BITS-1:0] i_key,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic                         o_status,
    output logic                         o_evicted_valid,
    output logic [lkc_pkg::KEY_BITS-1:0] o_evicted_key,
    output logic [lkc_pkg::OCC_W-1:0]    o_occupancy,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lkc_pkg::ADDR_W-1:0]   paddr,
    input  logic [lkc_pkg::DATA_W-1:0]   pwdata,
    output logic [lkc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import lkc_pkg::*;

    logic [CAP_W-1:0]    r_cap;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic                r_hit;
    logic                r_status;
    logic                r_ev_valid;
    logic [KEY_BITS-1:0] r_ev_key;
    logic [OCC_W-1:0]    r_occ;

    logic                n_hit;
    logic                n_status;
    logic                n_ev_valid;
    logic [KEY_BITS-1:0] n_ev_key;

    logic                w_in_acc;
    logic                w_cfg_wr;
    logic [CMP_W-1:0]    w_eff_cap;
    logic                w_full;
    logic                w_hit_any;
    logic                w_insert_ok;
    logic [KEY_BITS-1:0] w_lru_key;
    t_action             w_action;
    t_probe              w_probe;
    t_cell_cmd           w_cmd;

    logic [KEY_BITS-1:0] w_keys  [MAX_ENTRIES];
    logic [MAX_ENTRIES:0] w_mchain;

    assign w_action   = t_action'(i_action);
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // capacity zero acts as one, above the cell count it saturates
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(MAX_ENTRIES)) begin
            w_eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            w_eff_cap = CMP_W'(r_cap);
        end
    end

    assign w_full      = CMP_W'(r_count) >= w_eff_cap;
    assign w_hit_any   = w_mchain[0];
    assign w_insert_ok = (w_action == ACT_INSERT) && !w_hit_any;
    assign w_lru_key   = w_keys[IDX_W'(r_count - CNT_W'(1))];

    assign w_probe.key   = i_key;
    assign w_probe.count = r_count;

    assign w_cmd.lookup_en    = w_in_acc && (w_action == ACT_LOOKUP);
    assign w_cmd.insert_en    = w_in_acc && w_insert_ok;
    assign w_cmd.insert_limit = w_full ? (r_count - CNT_W'(1)) : r_count;

    assign w_mchain[MAX_ENTRIES] = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_left;
        if (g == 0) begin : g_head
            assign w_left = i_key;
        end else begin : g_body
            assign w_left = w_keys[g-1];
        end
        lkc_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_probe      (w_probe),
            .i_cmd        (w_cmd),
            .i_left_key   (w_left),
            .i_match_right(w_mchain[g+1]),
            .o_match_any  (w_mchain[g]),
            .o_key        (w_keys[g])
        );
    end

    always_comb begin
        n_hit      = 1'b0;
        n_status   = 1'b0;
        n_ev_valid = 1'b0;
        n_ev_key   = '0;
        n_count    = r_count;
        case (w_action)
            ACT_LOOKUP: begin
                n_hit = w_hit_any;
            end
            ACT_INSERT: begin
                if (w_hit_any) begin
                    n_status = 1'b1;
                end else if (w_full) begin
                    // lru drops off the end, count stays
                    n_ev_valid = 1'b1;
                    n_ev_key   = w_lru_key;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            ACT_EVICT: begin
                if (r_count != '0) begin
                    n_ev_valid = 1'b1;
                    n_ev_key   = w_lru_key;
                    n_count    = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_hit      <= n_hit;
            r_status   <= n_status;
            r_ev_valid <= n_ev_valid;
            r_ev_key   <= n_ev_key;
            r_occ      <= OCC_W'(n_count);
        end
    end

    // configuration register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(r_cap) : '0;

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_status        = r_status;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_key   = r_ev_key;
    assign o_occupancy     = r_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(MAX_ENTRIES))
        else $error("occupancy beyond cell count");

    a_hit_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_status))
        else $error("hit and duplicate status together");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid)
        else $error("accepted transaction without result");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_count))
        else $error("occupancy changed without a transaction");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_count == $past(r_count) ||
                      r_count == $past(r_count) + CNT_W'(1) ||
                      r_count + CNT_W'(1) == $past(r_count)))
        else $error("occupancy moved by more than one");

endmodule

>>> hw/rtl/lkc_cell.sv
`timescale 1ns / 1ps
module lkc_cell (
    input  logic                         i_clk,
    input  logic [lkc_pkg::IDX_W-1:0]    i_index,
    input  lkc_pkg::t_probe              i_probe,
    input  lkc_pkg::t_cell_cmd           i_cmd,
    input  logic [lkc_pkg::KEY_BITS-1:0] i_left_key,
    input  logic                         i_match_right,
    output logic                         o_match_any,
    output logic [lkc_pkg::KEY_BITS-1:0] o_key
);
    import lkc_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic [CNT_W-1:0]    w_pos;
    logic                w_valid;
    logic                w_match;
    logic                w_shift;

    // cell position equals recency rank, so a cell is valid below the count
    assign w_pos       = CNT_W'(i_index);
    assign w_valid     = w_pos < i_probe.count;
    assign w_match     = w_valid && (r_key == i_probe.key);
    assign o_match_any = w_match | i_match_right;

    // shift one place toward lru up to the hit cell or the insert limit
    assign w_shift = (i_cmd.lookup_en && o_match_any) ||
                     (i_cmd.insert_en && (w_pos <= i_cmd.insert_limit));

    always_comb begin
        n_key = w_shift ? i_left_key : r_key;
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;

endmodule

>>> tb/tb_lru_key_cache_core.sv
`timescale 1ns / 1ps
module tb_lru_key_cache_core;
    import lkc_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_CAPACITY = ADDR_W'(4 * int'(REG_CAPACITY));
    // first address past the register list, writes there must be dropped
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = ADDR_W'(4);
    localparam int                N_PHASES      = 12;
    localparam int                PHASE_ITEMS   = 120;

    typedef struct packed {
        logic                hit;
        logic                status;
        logic                evicted_valid;
        logic [KEY_BITS-1:0] evicted_key;
        logic [OCC_W-1:0]    occupancy;
    } t_cache_result;

    class cache_scoreboard;
        logic [KEY_BITS-1:0] slot_key [MAX_ENTRIES];
        int unsigned         slot_rank [MAX_ENTRIES];
        bit                  slot_used [MAX_ENTRIES];
        int unsigned         held;
        logic [CAP_W-1:0]    cap_reg;
        t_cache_result       expected_q [$];
        int unsigned         mismatches;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_rank[i] = 0;
                slot_key[i]  = '0;
            end
            held       = 0;
            cap_reg    = CAP_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(int unsigned index, logic [DATA_W-1:0] value);
            if (index == 32'(REG_CAPACITY)) cap_reg = value[CAP_W-1:0];
        endfunction

        function int unsigned eff_capacity();
            if (cap_reg == 0) return 1;
            if (cap_reg > MAX_ENTRIES) return MAX_ENTRIES;
            return cap_reg;
        endfunction

        function int find_slot(logic [KEY_BITS-1:0] key);
            foreach (slot_used[i])
                if (slot_used[i] && slot_key[i] == key) return i;
            return -1;
        endfunction

        function bit drop_lru(output logic [KEY_BITS-1:0] victim);
            victim = '0;
            if (held == 0) return 1'b0;
            foreach (slot_used[i]) begin
                if (slot_used[i] && slot_rank[i] == held - 1) begin
                    victim       = slot_key[i];
                    slot_used[i] = 1'b0;
                    slot_rank[i] = 0;
                    held--;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_input(t_action act, logic [KEY_BITS-1:0] key);
            t_cache_result       res;
            int                  slot;
            int unsigned         r;
            logic [KEY_BITS-1:0] victim;
            res  = '0;
            case (act)
                ACT_LOOKUP: begin
                    slot = find_slot(key);
                    if (slot >= 0) begin
                        res.hit = 1'b1;
                        r = slot_rank[slot];
                        foreach (slot_used[i])
                            if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
                        slot_rank[slot] = 0;
                    end
                end
                ACT_INSERT: begin
                    if (find_slot(key) >= 0) begin
                        res.status = 1'b1;
                    end else begin
                        if (held >= eff_capacity() && drop_lru(victim)) begin
                            res.evicted_valid = 1'b1;
                            res.evicted_key   = victim;
                        end
                        slot = -1;
                        foreach (slot_used[i])
                            if (!slot_used[i] && slot < 0) slot = i;
                        if (slot >= 0) begin
                            foreach (slot_used[i])
                                if (slot_used[i]) slot_rank[i]++;
                            slot_key[slot]  = key;
                            slot_rank[slot] = 0;
                            slot_used[slot] = 1'b1;
                            held++;
                        end
                    end
                end
                ACT_EVICT: begin
                    if (drop_lru(victim)) begin
                        res.evicted_valid = 1'b1;
                        res.evicted_key   = victim;
                    end
                end
                default: ;
            endcase
            res.occupancy = OCC_W'(held);
            expected_q.push_back(res);
        endfunction

        function void flag(string why, t_cache_result e, t_cache_result g);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t %s: expected hit=%0b status=%0b ev=%0b key=%h occ=%0d",
                         $time, why, e.hit, e.status, e.evicted_valid, e.evicted_key,
                         e.occupancy);
                $display("%0t %s: got      hit=%0b status=%0b ev=%0b key=%h occ=%0d",
                         $time, why, g.hit, g.status, g.evicted_valid, g.evicted_key,
                         g.occupancy);
            end
        endfunction

        function void check_result(t_cache_result got);
            t_cache_result exp_res;
            if (expected_q.size() == 0) begin
                flag("unexpected result", '0, got);
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.hit !== exp_res.hit || got.status !== exp_res.status ||
                got.evicted_valid !== exp_res.evicted_valid ||
                got.evicted_key !== exp_res.evicted_key ||
                got.occupancy !== exp_res.occupancy)
                flag("result mismatch", exp_res, got);
        endfunction

        function void check_capacity_read(logic [DATA_W-1:0] got);
            if (got !== DATA_W'(cap_reg)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t capacity read: expected %0d, got %h", $time, cap_reg, got);
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_action = ACT_NOP;
    logic [KEY_BITS-1:0] i_key = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_hit;
    logic                o_status;
    logic                o_evicted_valid;
    logic [KEY_BITS-1:0] o_evicted_key;
    logic [OCC_W-1:0]    o_occupancy;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cache_scoreboard sb = new();
    int unsigned     burst_left = 0;
    int unsigned     stall_mode = 0;
    int unsigned     stall_left = 0;

    lru_key_cache_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_key           (i_key),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_status        (o_status),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key),
        .o_occupancy     (o_occupancy),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver stall pattern: free running, light random stalls, or heavy random stalls
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 96);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            sb.check_result('{o_hit, o_status, o_evicted_valid, o_evicted_key, o_occupancy});
    end

    task automatic hold_off(int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic send_op(t_action act, logic [KEY_BITS-1:0] key);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_key      <= key;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_input(act, key);
    endtask

    task automatic drain();
        hold_off(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(32'(addr >> 2), data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_capacity();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_CAPACITY;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.check_capacity_read(prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_capacity(logic [DATA_W-1:0] value);
        drain();
        apb_write(ADDR_CAPACITY, value);
        check_capacity();
    endtask

    task automatic run_phase(logic [DATA_W-1:0] cap_value, int unsigned n_items);
        logic [KEY_BITS-1:0] pool [$];
        logic [KEY_BITS-1:0] key;
        int unsigned         pool_n;
        int unsigned         r;
        t_action             act;
        set_capacity(cap_value);
        // a small key pool per phase so lookups hit and inserts collide
        pool_n = $urandom_range(3, 40);
        repeat (pool_n) pool.push_back($urandom);
        for (int n = 0; n < n_items; n++) begin
            if (n == n_items / 2) drain();
            r = $urandom_range(0, 99);
            if (r < 40)      act = ACT_LOOKUP;
            else if (r < 80) act = ACT_INSERT;
            else if (r < 92) act = ACT_EVICT;
            else             act = ACT_NOP;
            r = $urandom_range(0, 99);
            if (r < 80)      key = pool[$urandom_range(0, pool_n - 1)];
            else if (r < 85) key = '0;
            else if (r < 90) key = '1;
            else             key = $urandom;
            send_op(act, key);
        end
    endtask

    initial begin
        logic [DATA_W-1:0] phase_caps [N_PHASES];
        phase_caps = '{32'd16, 32'd1, 32'd31, 32'd8, 32'd0, 32'd16,
                       32'd3, 32'hFFFF_FFE4, 32'd20, 32'd2, 32'd12, 32'd16};
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset capacity, empty store, duplicates, hits and misses
        send_op(ACT_LOOKUP, 32'h0000_0000);
        send_op(ACT_EVICT,  32'h0000_0000);
        send_op(ACT_NOP,    32'hFFFF_FFFF);
        send_op(ACT_INSERT, 32'h0000_0000);
        send_op(ACT_INSERT, 32'hFFFF_FFFF);
        send_op(ACT_INSERT, 32'h0000_0000);
        send_op(ACT_LOOKUP, 32'hFFFF_FFFF);
        send_op(ACT_LOOKUP, 32'h0000_0000);
        send_op(ACT_LOOKUP, 32'h5A5A_5A5A);
        send_op(ACT_EVICT,  32'h0000_0000);
        send_op(ACT_INSERT, 32'h0000_0001);
        send_op(ACT_INSERT, 32'h8000_0000);
        send_op(ACT_NOP,    32'h0000_0000);

        // capacity dropped below occupancy
        set_capacity(32'd1);
        send_op(ACT_INSERT, 32'h1234_5678);
        send_op(ACT_LOOKUP, 32'h0000_0001);
        send_op(ACT_INSERT, 32'hA5A5_A5A5);
        repeat (4) send_op(ACT_EVICT, 32'hFFFF_FFFF);

        // zero capacity behaves as one
        set_capacity(32'd0);
        send_op(ACT_INSERT, 32'h0000_0007);
        send_op(ACT_INSERT, 32'h0000_0008);
        send_op(ACT_INSERT, 32'h0000_0008);

        // write past the register list is dropped
        drain();
        apb_write(ADDR_UNMAPPED, 32'd3);
        check_capacity();
        send_op(ACT_INSERT, 32'h0000_0009);

        foreach (phase_caps[p]) run_phase(phase_caps[p], PHASE_ITEMS);

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
